/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define PRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* src/prt_pkg.sv */
// shared types and constants of the pending request retry table
// no dependencies
package prt_pkg;

    // input command codes
    typedef enum logic [1:0] {
        CMD_OPEN     = 2'd0,
        CMD_RESPONSE = 2'd1,
        CMD_TICK     = 2'd2
    } t_cmd;

    // result kinds
    typedef enum logic [2:0] {
        KIND_OPENED    = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_MATCHED   = 3'd2,
        KIND_UNMATCHED = 3'd3,
        KIND_RESEND    = 3'd4,
        KIND_TIMED_OUT = 3'd5
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN_SCAN,
        ST_RESP_READ,
        ST_RESP_CHECK,
        ST_TICK_READ,
        ST_TICK_EVAL,
        ST_FLUSH
    } t_state;

    // configuration port decode: register select is paddr bit 2
    localparam int   PADDR_W     = 3;
    localparam int   PDATA_W     = 32;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRY   = 1'b1;

    localparam logic [7:0] TIMEOUT_RESET = 8'd3;
    localparam logic [7:0] RETRY_RESET   = 8'd3;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [15:0] handler_tag;
        logic [15:0] remote_addr;
        logic [15:0] local_addr;
        logic [8:0]  time_left;
        logic [7:0]  retries_left;
    } t_entry;

    // verdict of the entry update unit
    typedef struct packed {
        logic  emit;
        t_kind kind;
        logic  release_entry;
        logic  write_back;
    } t_eval;

    // one result transaction
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  result_id;
        logic [15:0] result_handler;
        logic [15:0] result_remote;
        logic [15:0] result_local;
    } t_result;

endpackage

/* src/prt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/prt_upd.sv */
// shared entry update unit: response match and tick countdown/retry step
// depends on prt_pkg
module prt_upd import prt_pkg::*; (
    input  logic        i_tick,
    input  t_entry      i_entry,
    input  logic [15:0] i_rx_remote,
    input  logic [15:0] i_rx_local,
    input  logic [7:0]  i_timeout,
    output t_eval       o_eval,
    output t_entry      o_entry
);

    logic addr_match;

    assign addr_match = (i_entry.remote_addr == i_rx_remote) &&
                        (i_entry.local_addr == i_rx_local);

    always_comb begin
        o_eval  = '{emit: 1'b0, kind: KIND_UNMATCHED, release_entry: 1'b0,
                    write_back: 1'b0};
        o_entry = i_entry;
        if (!i_tick) begin
            // response: free the entry only if both endpoints match
            o_eval.emit          = 1'b1;
            o_eval.kind          = addr_match ? KIND_MATCHED : KIND_UNMATCHED;
            o_eval.release_entry = addr_match;
        end else if (i_entry.time_left != 9'd0) begin
            // countdown still running
            o_eval.write_back = 1'b1;
            o_entry.time_left = i_entry.time_left - 9'd1;
        end else if (i_entry.retries_left > 8'd1) begin
            // underflow with budget left: reload and resend
            o_eval.emit          = 1'b1;
            o_eval.kind          = KIND_RESEND;
            o_eval.write_back    = 1'b1;
            o_entry.retries_left = i_entry.retries_left - 8'd1;
            o_entry.time_left    = {1'b0, i_timeout};
        end else begin
            // underflow with budget spent: give up
            o_eval.emit          = 1'b1;
            o_eval.kind          = KIND_TIMED_OUT;
            o_eval.release_entry = 1'b1;
        end
    end

endmodule

/* src/prt_ctrl.sv */
// sequencer: valid bits, entry walk, result staging and output register
// depends on prt_pkg; drives prt_ram and prt_upd through the top level
module prt_ctrl import prt_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_invoke_id,
    input  logic [15:0]      i_remote_addr,
    input  logic [15:0]      i_local_addr,
    input  logic [15:0]      i_handler_tag,
    // configuration
    input  logic [7:0]       i_timeout,
    input  logic [7:0]       i_retry,
    // entry ram
    output logic             o_ram_we,
    output logic [IDX_W-1:0] o_ram_waddr,
    output t_entry           o_ram_wdata,
    output logic             o_ram_re,
    output logic [IDX_W-1:0] o_ram_raddr,
    input  t_entry           i_ram_rdata,
    // update unit
    output logic             o_upd_tick,
    output logic [15:0]      o_rx_remote,
    output logic [15:0]      o_rx_local,
    input  t_eval            i_eval,
    input  t_entry           i_upd_entry,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output t_result          o_result,
    output logic             o_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [1:0]             r_cmd, n_cmd;
    logic [7:0]             r_id, n_id;
    logic [15:0]            r_remote, n_remote;
    logic [15:0]            r_local, n_local;
    logic [15:0]            r_tag, n_tag;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic                   r_pend_valid, n_pend_valid;
    t_result                r_pend, n_pend;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;
    logic                   r_out_last, n_out_last;

    logic             slot_free;
    logic             id_in_range;
    logic [IDX_W-1:0] rx_idx;

    assign slot_free   = !r_out_valid || !i_stall;
    assign id_in_range = {1'b0, r_id} < 9'(TABLE_DEPTH);
    assign rx_idx      = r_id[IDX_W-1:0];

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_remote   <= n_remote;
        r_local    <= n_local;
        r_tag      <= n_tag;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_remote     = r_remote;
        n_local      = r_local;
        n_tag        = r_tag;
        n_valid      = r_valid;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && i_stall;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = i_upd_entry;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_id     = i_invoke_id;
                    n_remote = i_remote_addr;
                    n_local  = i_local_addr;
                    n_tag    = i_handler_tag;
                    n_idx    = '0;
                    case (i_command)
                        CMD_OPEN:     n_state = ST_OPEN_SCAN;
                        CMD_RESPONSE: n_state = ST_RESP_READ;
                        CMD_TICK:     n_state = ST_TICK_READ;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end

            // walk to the lowest free id
            ST_OPEN_SCAN: begin
                if (!r_valid[r_idx]) begin
                    o_ram_we     = 1'b1;
                    o_ram_wdata  = '{handler_tag: r_tag, remote_addr: r_remote,
                                     local_addr: r_local,
                                     time_left: {1'b0, i_timeout},
                                     retries_left: i_retry};
                    n_valid[r_idx] = 1'b1;
                    n_pend       = '{kind: KIND_OPENED, result_id: 8'(r_idx),
                                     default: '0};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end else if (r_idx == LAST_IDX) begin
                    n_pend       = '{kind: KIND_FULL, default: '0};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // fetch the addressed entry if it can match at all
            ST_RESP_READ: begin
                if (id_in_range && r_valid[rx_idx]) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = rx_idx;
                    n_state     = ST_RESP_CHECK;
                end else begin
                    n_pend       = '{kind: KIND_UNMATCHED, result_id: r_id,
                                     default: '0};
                    n_pend_valid = 1'b1;
                    n_state      = ST_FLUSH;
                end
            end

            ST_RESP_CHECK: begin
                n_pend = '{kind: i_eval.kind, result_id: r_id, default: '0};
                if (i_eval.release_entry) begin
                    n_pend.result_handler = i_ram_rdata.handler_tag;
                    n_valid[rx_idx]       = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_state      = ST_FLUSH;
            end

            // tick: skip free entries, fetch valid ones
            ST_TICK_READ: begin
                if (r_valid[r_idx]) begin
                    o_ram_re = 1'b1;
                    n_state  = ST_TICK_EVAL;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // tick: apply the update, stage any result behind the previous one
            ST_TICK_EVAL: begin
                if (!i_eval.emit || !r_pend_valid || slot_free) begin
                    o_ram_we = i_eval.write_back;
                    if (i_eval.release_entry) begin
                        n_valid[r_idx] = 1'b0;
                    end
                    if (i_eval.emit) begin
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out_last  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        n_pend       = '{kind: i_eval.kind, result_id: 8'(r_idx),
                                         result_handler: i_ram_rdata.handler_tag,
                                         result_remote: i_ram_rdata.remote_addr,
                                         result_local: i_ram_rdata.local_addr};
                        n_pend_valid = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_TICK_READ;
                    end
                end
            end

            // hand the final staged result over with last set
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (slot_free) begin
                    n_out        = r_pend;
                    n_out_last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_upd_tick  = (r_state == ST_TICK_EVAL);
    assign o_rx_remote = r_remote;
    assign o_rx_local  = r_local;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign o_last      = r_out_last;

endmodule

/* src/pending_request_retry_table_top.sv */
// top level of the pending request retry table
// depends on prt_pkg, prt_ram, prt_upd, prt_ctrl
//
// Client-side table of outstanding confirmed requests, indexed by invoke id.
// Request channel (i_valid / o_stall): command 0 opens a request at the lowest
// free id, 1 delivers a response (id + both endpoints), 2 is a timer tick,
// 3 is a no-op. Result channel (o_valid / i_stall): one transaction per
// result, o_last marks the final result of a request.
// Sequencing: the block takes one request at a time. An open scans one id per
// cycle; a response reads and checks the addressed entry when it is valid; a
// tick skips each free id and reads, then evaluates, each valid id (single
// entry-ram port feeding the shared update unit). Results pass through a staging
// register into the output register.
// Reset clears all valid bits and sets both registers to 3; the block is ready
// right after reset. When the receiver stalls, the output register holds and
// the sequencer waits once a second result is staged behind it.
// Registers: 0x0 timeout_ticks, 0x4 retry_limit (bits 7:0).
module pending_request_retry_table_top import prt_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_invoke_id,
    input  logic [15:0]        i_remote_addr,
    input  logic [15:0]        i_local_addr,
    input  logic [15:0]        i_handler_tag,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_result_id,
    output logic [15:0]        o_result_handler,
    output logic [15:0]        o_result_remote,
    output logic [15:0]        o_result_local,
    output logic               o_last,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0]       r_timeout;
    logic [7:0]       r_retry;
    logic             cfg_write;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;

    logic             upd_tick;
    logic [15:0]      rx_remote;
    logic [15:0]      rx_local;
    t_eval            eval;
    t_entry           upd_entry;
    t_result          result;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_retry   <= RETRY_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_RETRY) begin
                r_retry <= pwdata[7:0];
            end else begin
                r_timeout <= pwdata[7:0];
            end
        end
    end

    // register read back
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {24'd0, r_timeout} : {24'd0, r_retry};

    // entry storage
    prt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared update unit
    prt_upd u_upd (
        .i_tick      (upd_tick),
        .i_entry     (ram_rdata),
        .i_rx_remote (rx_remote),
        .i_rx_local  (rx_local),
        .i_timeout   (r_timeout),
        .o_eval      (eval),
        .o_entry     (upd_entry)
    );

    // sequencer
    prt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_invoke_id   (i_invoke_id),
        .i_remote_addr (i_remote_addr),
        .i_local_addr  (i_local_addr),
        .i_handler_tag (i_handler_tag),
        .i_timeout     (r_timeout),
        .i_retry       (r_retry),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_upd_tick    (upd_tick),
        .o_rx_remote   (rx_remote),
        .o_rx_local    (rx_local),
        .i_eval        (eval),
        .i_upd_entry   (upd_entry),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (result),
        .o_last        (o_last)
    );

    // result fields
    assign o_kind           = result.kind;
    assign o_result_id      = result.result_id;
    assign o_result_handler = result.result_handler;
    assign o_result_remote  = result.result_remote;
    assign o_result_local   = result.result_local;

endmodule

/* src/prt_checker.sv */
// port-level checks of the pending request retry table, bound to the top
// depends on prt_pkg and assert_macros.svh
`include "assert_macros.svh"

module prt_checker import prt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_command,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_result_id,
    input logic [15:0] o_result_handler,
    input logic [15:0] o_result_remote,
    input logic [15:0] o_result_local,
    input logic        o_last
);

    logic        take_cmd;
    logic        single_kind;
    logic [59:0] out_word;
    logic        handles_zero;

    // helper terms for the properties below
    assign take_cmd     = i_valid && !o_stall &&
                          (i_command inside {CMD_OPEN, CMD_RESPONSE, CMD_TICK});
    assign single_kind  = o_kind inside {KIND_OPENED, KIND_FULL, KIND_MATCHED,
                                         KIND_UNMATCHED};
    assign out_word     = {o_kind, o_result_id, o_result_handler, o_result_remote,
                           o_result_local, o_last};
    assign handles_zero = (o_result_handler == 16'd0) && (o_result_remote == 16'd0) &&
                          (o_result_local == 16'd0);

    // a stalled result transaction holds
    `PRT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

    // a real command keeps the block busy in the following cycle
    `PRT_ASSERT_NXT(a_busy_after_cmd, i_clk, i_rst_n, take_cmd, o_stall)

    // open and response commands give a single result
    `PRT_ASSERT_IMP(a_single_result, i_clk, i_rst_n, o_valid && single_kind, o_last)

    // opened results carry no stored handles
    `PRT_ASSERT_IMP(a_opened_clean, i_clk, i_rst_n, o_valid && o_kind == KIND_OPENED, handles_zero)

endmodule

bind pending_request_retry_table_top prt_checker u_prt_checker (.*);
